FILE: hdl/aest_pkg.sv
// Shared types, constants and register indexes of the event sampling throttle.
`default_nettype none
package aest_pkg;

    localparam int TS_W   = 64;
    localparam int CNT_W  = 32;
    localparam int WM_W   = 16;
    localparam int DIV_W  = 8;
    localparam int IDX_W  = 2;

    // register indexes on the config port
    localparam logic [IDX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_WATERMARK = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_DIV   = 2'd2;
    localparam logic [IDX_W-1:0] REG_WINDOW    = 2'd3;

    // reset values of the registers
    localparam logic             RST_ENABLE    = 1'b1;
    localparam logic [WM_W-1:0]  RST_WATERMARK = 16'd1500;
    localparam logic [DIV_W-1:0] RST_MAX_DIV   = 8'd8;
    localparam logic [TS_W-1:0]  RST_WINDOW    = 64'd10000000;

    localparam logic [DIV_W-1:0] MIN_DIVISOR   = 8'd2;
    localparam logic [CNT_W-1:0] SEEN_MAX      = {CNT_W{1'b1}};

    // divider runs one quotient bit per cycle
    localparam int STEP_W = $clog2(CNT_W);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(CNT_W - 1);

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quotient;
        logic [CNT_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SUB  = 7'b0000010,
        S_WIN  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV1 = 7'b0010000,
        S_DIV2 = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/aest_div.sv
// Shared restoring divider: 32-bit quotient and remainder, one bit per cycle.
`default_nettype none
module aest_div
    import aest_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    shifted;
    logic              fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[CNT_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? CNT_W'(shifted - {1'b0, den_reg}) : shifted[CNT_W-1:0];
        quo_next = {quo_reg[CNT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

FILE: hdl/adaptive_event_sampling_throttle.sv
// Top level of the adaptive event sampling throttle: sequencer, state and config.
// Usage:
//   Input channel (in_valid/in_ready/timestamp) takes one event per item; the
//   output channel (out_valid/out_ready/record) returns one record bit per item,
//   in order. Config is a plain write port (cfg_write, cfg_index, cfg_data):
//   0 enable, 1 high watermark, 2 max divisor, 3 window ticks. Write only idle.
// Steps per item, from accept to out_valid high:
//   throttle off or zero window : straight to the finish state
//   at or under the watermark   : subtract, window update, check, finish
//   sampled (past watermark)    : as above, then two passes of the shared
//                                 one-bit-per-cycle divider (load, then bit steps):
//                                 overflow/watermark, then token%divisor; finish.
// One item is in flight at a time; in_ready is high only in the idle state.
// The output register holds a finished result while the receiver stalls; the
// next item may be accepted meanwhile, and it waits in its last state until
// the output register frees up.
// Reset: config returns to enable=1, watermark=1500, max divisor=8,
// window=10000000; window start, seen count and sample token clear to zero
// (no window open). No clearing pass is needed.
`default_nettype none
module adaptive_event_sampling_throttle
    import aest_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [TS_W-1:0]   timestamp,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   record,
    input  wire logic              cfg_write,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [TS_W-1:0]   cfg_data
);

    // configuration
    logic             enable_reg;
    logic [WM_W-1:0]  hw_reg;
    logic [DIV_W-1:0] max_div_reg;
    logic [TS_W-1:0]  window_reg;

    // block state
    logic [TS_W-1:0]  win_start_reg;
    logic [CNT_W-1:0] seen_reg;
    logic [CNT_W-1:0] token_reg;

    // per-item work registers
    state_t           state_reg, state_next;
    logic [TS_W-1:0]  ts_reg;
    logic [TS_W-1:0]  diff_reg;
    logic             back_reg;
    logic             rec_reg, rec_next;
    logic             out_valid_reg;
    logic             record_reg;

    div_req_t         div_req;
    div_rsp_t         div_rsp;

    // helper signals
    logic [TS_W:0]    diff_full;
    logic             open_win;
    logic [CNT_W-1:0] seen_base;
    logic [CNT_W-1:0] token_base;
    logic             sampled;
    logic [DIV_W-1:0] limit;
    logic [CNT_W:0]   div_sum;
    logic [DIV_W-1:0] divisor;
    logic             out_free;

    aest_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign record    = record_reg;

    always_comb
    begin
        diff_full  = {1'b0, ts_reg} - {1'b0, win_start_reg};
        open_win   = (win_start_reg == '0) || back_reg || (diff_reg >= window_reg);
        seen_base  = open_win ? '0 : seen_reg;
        token_base = open_win ? '0 : token_reg;
        sampled    = (hw_reg != '0) && (seen_reg > {{(CNT_W-WM_W){1'b0}}, hw_reg});
        limit      = (max_div_reg < MIN_DIVISOR) ? MIN_DIVISOR : max_div_reg;
        // divisor = 2 + overflow/watermark, clamped to the limit
        div_sum    = {1'b0, div_rsp.quotient} + (CNT_W+1)'(MIN_DIVISOR);
        divisor    = (div_sum > (CNT_W+1)'(limit)) ? limit : div_sum[DIV_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        rec_next         = rec_reg;
        div_req.start    = 1'b0;
        div_req.dividend = seen_reg - {{(CNT_W-WM_W){1'b0}}, hw_reg};
        div_req.divisor  = {{(CNT_W-WM_W){1'b0}}, hw_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!enable_reg || window_reg == '0)
                    begin
                        rec_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SUB;
                    end
                end
            end
            S_SUB:
            begin
                state_next = S_WIN;
            end
            S_WIN:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sampled)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV1;
                end
                else
                begin
                    rec_next   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = token_reg;
                    div_req.divisor  = {{(CNT_W-DIV_W){1'b0}}, divisor};
                    state_next       = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    rec_next   = (div_rsp.remainder == '0);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            enable_reg    <= RST_ENABLE;
            hw_reg        <= RST_WATERMARK;
            max_div_reg   <= RST_MAX_DIV;
            window_reg    <= RST_WINDOW;
            win_start_reg <= '0;
            seen_reg      <= '0;
            token_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ENABLE:    enable_reg  <= cfg_data[0];
                    REG_WATERMARK: hw_reg      <= cfg_data[WM_W-1:0];
                    REG_MAX_DIV:   max_div_reg <= cfg_data[DIV_W-1:0];
                    REG_WINDOW:    window_reg  <= cfg_data;
                    default:       ;
                endcase
            end

            // window open/refresh and saturating seen count
            if (state_reg == S_WIN)
            begin
                if (open_win)
                begin
                    win_start_reg <= ts_reg;
                end
                seen_reg  <= (seen_base == SEEN_MAX) ? seen_base : seen_base + 1'b1;
                token_reg <= token_base;
            end

            if (state_reg == S_CHK && sampled)
            begin
                token_reg <= token_reg + 1'b1;
            end

            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (in_valid && in_ready)
        begin
            ts_reg <= timestamp;
        end
        if (state_reg == S_SUB)
        begin
            diff_reg <= diff_full[TS_W-1:0];
            back_reg <= diff_full[TS_W];
        end
        if (state_reg == S_FIN && out_free)
        begin
            record_reg <= rec_reg;
        end
    end

endmodule
`default_nettype wire
